/* rtl/core/otach_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants for the optical tachometer.
// No dependencies; imported by the divider and the top level.
package otach_pkg;

  localparam int NUM_SENSORS   = 2;
  localparam int HISTORY_DEPTH = 8;

  // Input word kinds
  localparam logic [1:0] KIND_SAMPLE = 2'd0;
  localparam logic [1:0] KIND_TICK   = 2'd1;
  localparam logic [1:0] KIND_ARM    = 2'd2;

  // Register indexes (paddr[3:2])
  localparam logic [1:0] REG_RPM_NUM    = 2'd0;
  localparam logic [1:0] REG_CHANGE_MIN = 2'd1;
  localparam logic [1:0] REG_MARGIN     = 2'd2;

  localparam logic [31:0] RPM_NUM_RESET    = 32'd187500000;
  localparam logic [7:0]  CHANGE_MIN_RESET = 8'd10;
  localparam logic [6:0]  MARGIN_RESET     = 7'd5;
  localparam logic [7:0]  HIGH_THR_RESET   = 8'd5;

  localparam logic [31:0] TICKS_MAX = 32'hFFFF_FFFF;

  typedef struct packed {
    logic [1:0] kind;
    logic       sensor;
    logic [9:0] adc_sample;
  } in_word_t;

  typedef struct packed {
    logic        sensor_out;
    logic        level;
    logic        edge_detected;
    logic        rpm_valid;
    logic [31:0] rpm_x10;
    logic [2:0]  rpm_slot;
    logic [1:0]  anim_phase;
    logic        measure_done;
    logic [7:0]  threshold_high;
    logic [7:0]  threshold_low;
  } out_word_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EVAL,
    ST_DIV,
    ST_OUT
  } tach_state_t;

endpackage

/* rtl/core/otach_div.sv */
`timescale 1ns / 1ps
// Restoring 32-bit unsigned divider, one quotient bit per cycle.
// Depends on otach_pkg for the status struct.
module otach_div import otach_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [31:0] dividend,
  input  logic [31:0] divisor,
  output logic [31:0] quotient,
  output div_status_t status
);

  logic [31:0] rem_r, rem_nxt;
  logic [31:0] quo_r, quo_nxt;
  logic [31:0] dvs_r;
  logic [4:0]  cnt_r;
  logic        busy_r;
  logic        done_r;
  logic [32:0] shifted;
  logic        ge;

  always_comb begin
    shifted = {rem_r, quo_r[31]};
    ge      = shifted >= {1'b0, dvs_r};
    rem_nxt = ge ? 32'(shifted - {1'b0, dvs_r}) : shifted[31:0];
    quo_nxt = {quo_r[30:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 5'd1;
        if (cnt_r == 5'd31) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= dividend;
      dvs_r <= divisor;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
  end

  assign quotient    = quo_r;
  assign status.busy = busy_r;
  assign status.done = done_r;

`ifndef NO_ASSERTIONS
  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> !busy_r) else $error("divider started while busy");
  a_last_step: assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r && !start && cnt_r == 5'd31) |=> (done_r && !busy_r))
    else $error("divider missed its done pulse");
  a_done_alone: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> !busy_r) else $error("divider done while still busy");
`endif

endmodule

/* rtl/core/optical_tachometer_adaptive_hysteresis_unit.sv */
`timescale 1ns / 1ps
// An accepted sample word is held in in_r, evaluated into res_r in ST_EVAL, sent
// through the shared restoring divider in ST_DIV when it yields an rpm value, and
// loaded into the output register in ST_OUT once it is free. Tick and arm words are
// taken back to back while idle; a sample blocks in_ready until its result is loaded.
// Reset (rst_n, synchronous): registers to defaults, done flag set, all sensors low.
module optical_tachometer_adaptive_hysteresis_unit import otach_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_word_t    in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_word_t   out_data,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // Configuration registers
  logic [31:0] rpm_num_r;
  logic [7:0]  change_min_r;
  logic [6:0]  margin_r;

  // Shared measurement state
  logic [31:0] elapsed_r;
  logic        first_r;
  logic        done_r;

  // Per-sensor state
  logic       lvl_r   [NUM_SENSORS];
  logic [7:0] hi_r    [NUM_SENSORS];
  logic [7:0] lo_r    [NUM_SENSORS];
  logic [7:0] hn_r    [NUM_SENSORS];
  logic [7:0] ho_r    [NUM_SENSORS];
  logic [2:0] ring_r  [NUM_SENSORS];
  logic [1:0] anim_r  [NUM_SENSORS];

  tach_state_t state_r, state_nxt;
  in_word_t    in_r;
  out_word_t   res_r, res_nxt;
  out_word_t   out_r, out_nxt;
  logic        out_valid_r;

  logic        accept, sens_ok, out_load, div_start;
  logic        s;
  logic [7:0]  v;
  logic        rise, fall, div_go, upd;
  logic        lvl_nxt;
  logic [7:0]  hi_nxt, lo_nxt;
  logic [2:0]  ring_nxt;
  logic [1:0]  anim_nxt;
  logic        first_nxt, done_nxt;
  logic [7:0]  diff;
  logic [8:0]  avg, hi_sum;
  logic [31:0] quotient;
  div_status_t div_stat;

  assign pready = 1'b1;
  assign accept = in_valid && in_ready;
  assign sens_ok = int'(in_data.sensor) < NUM_SENSORS;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rpm_num_r    <= RPM_NUM_RESET;
      change_min_r <= CHANGE_MIN_RESET;
      margin_r     <= MARGIN_RESET;
    end else if (psel && penable && pwrite && pready) begin
      case (paddr[3:2])
        REG_RPM_NUM:    rpm_num_r    <= pwdata;
        REG_CHANGE_MIN: change_min_r <= pwdata[7:0];
        REG_MARGIN:     margin_r     <= pwdata[6:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_RPM_NUM:    prdata = rpm_num_r;
      REG_CHANGE_MIN: prdata = {24'd0, change_min_r};
      REG_MARGIN:     prdata = {25'd0, margin_r};
      default:        prdata = '0;
    endcase
  end

  // Sample evaluation for the held word
  always_comb begin
    s        = in_r.sensor;
    v        = in_r.adc_sample[9:2];
    rise     = (v > hi_r[s]) && !lvl_r[s];
    lvl_nxt  = rise ? 1'b1 : lvl_r[s];
    first_nxt = first_r;
    done_nxt  = done_r;
    div_go    = 1'b0;
    ring_nxt  = ring_r[s];
    anim_nxt  = anim_r[s];
    res_nxt   = '0;
    if (rise) begin
      anim_nxt = anim_r[s] + 2'd1;
      if (first_r) begin
        first_nxt = 1'b0;
      end else if (!done_r) begin
        done_nxt = 1'b1;
        if (elapsed_r != '0) begin
          div_go           = 1'b1;
          res_nxt.rpm_slot = ring_r[s];
          ring_nxt = ({1'b0, ring_r[s]} + 4'd1 >= 4'(HISTORY_DEPTH)) ?
                     3'd0 : ring_r[s] + 3'd1;
        end
      end
    end
    fall = (v < lo_r[s]) && lvl_nxt;
    if (fall) begin
      lvl_nxt = 1'b0;
    end
    diff   = (v > hn_r[s]) ? v - hn_r[s] : hn_r[s] - v;
    upd    = diff > change_min_r;
    avg    = ({1'b0, v} + {1'b0, hn_r[s]}) >> 1;
    hi_sum = avg + {2'b00, margin_r};
    hi_nxt = upd ? ((hi_sum > 9'd255) ? 8'hFF : hi_sum[7:0]) : hi_r[s];
    lo_nxt = upd ? ((avg >= {2'b00, margin_r}) ? 8'(avg - {2'b00, margin_r}) : 8'd0)
                 : lo_r[s];
    res_nxt.sensor_out     = s;
    res_nxt.level          = lvl_nxt;
    res_nxt.edge_detected  = rise;
    res_nxt.rpm_valid      = div_go;
    res_nxt.anim_phase     = anim_nxt;
    res_nxt.measure_done   = done_nxt;
    res_nxt.threshold_high = hi_nxt;
    res_nxt.threshold_low  = lo_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    in_ready  = 1'b0;
    div_start = 1'b0;
    out_load  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid && in_data.kind == KIND_SAMPLE && sens_ok) begin
          state_nxt = ST_EVAL;
        end
      end
      ST_EVAL: begin
        div_start = div_go;
        state_nxt = div_go ? ST_DIV : ST_OUT;
      end
      ST_DIV: begin
        if (div_stat.done) begin
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_valid_r || out_ready) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      elapsed_r   <= '0;
      first_r     <= 1'b0;
      done_r      <= 1'b1;
      for (int i = 0; i < NUM_SENSORS; i++) begin
        lvl_r[i]  <= 1'b0;
        hi_r[i]   <= HIGH_THR_RESET;
        lo_r[i]   <= '0;
        hn_r[i]   <= '0;
        ho_r[i]   <= '0;
        ring_r[i] <= '0;
        anim_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (accept && in_data.kind == KIND_TICK && elapsed_r != TICKS_MAX) begin
        elapsed_r <= elapsed_r + 32'd1;
      end
      if (accept && in_data.kind == KIND_ARM) begin
        first_r <= 1'b1;
        done_r  <= 1'b0;
      end
      if (state_r == ST_EVAL) begin
        // commit the sample's effect on the sensor and the shared counter
        if (rise) begin
          elapsed_r <= '0;
        end
        first_r   <= first_nxt;
        done_r    <= done_nxt;
        lvl_r[s]  <= lvl_nxt;
        hi_r[s]   <= hi_nxt;
        lo_r[s]   <= lo_nxt;
        ring_r[s] <= ring_nxt;
        anim_r[s] <= anim_nxt;
        if (upd) begin
          ho_r[s] <= hn_r[s];
          hn_r[s] <= v;
        end
      end
    end
  end

  // Merge the quotient into the held result word
  always_comb begin
    out_nxt         = res_r;
    out_nxt.rpm_x10 = res_r.rpm_valid ? quotient : 32'd0;
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      in_r <= in_data;
    end
    if (state_r == ST_EVAL) begin
      res_r <= res_nxt;
    end
    if (out_load) begin
      out_r <= out_nxt;
    end
  end

  otach_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (rpm_num_r),
    .divisor  (elapsed_r),
    .quotient (quotient),
    .status   (div_stat)
  );

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

`ifndef NO_ASSERTIONS
  a_div_wait: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) |-> (div_stat.busy || div_stat.done))
    else $error("waiting on an idle divider");
  a_rpm_edge: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.rpm_valid) |-> (out_r.edge_detected && out_r.measure_done))
    else $error("rpm word without a finishing edge");
  a_rpm_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_r.rpm_valid) |-> (out_r.rpm_x10 == '0 && out_r.rpm_slot == '0))
    else $error("rpm fields set without rpm_valid");
  a_tick_count: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_data.kind == KIND_TICK && elapsed_r != TICKS_MAX)
    |=> (elapsed_r == $past(elapsed_r) + 32'd1))
    else $error("tick counter did not advance");
`endif

endmodule
